// File: sv/cowsb_pkg.sv
// ----------------------------------------------------------------------------
// cowsb_pkg
// Shared constants and codes for the copy-on-write sector bitmap engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cowsb_pkg;

  localparam int DISK_SECTORS = 65536;
  localparam int WORD_BITS    = 32;
  localparam int MASK_BITS    = 32;
  localparam int BITMAP_WORDS = (DISK_SECTORS + WORD_BITS - 1) / WORD_BITS;

  localparam int WORD_IDX_W = $clog2(BITMAP_WORDS);
  localparam int BIT_OFF_W  = $clog2(WORD_BITS);
  localparam int SECTOR_W   = 16;
  localparam int COUNT_W    = 8;
  localparam int END_W      = 12;
  localparam int PADDR_W    = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  localparam logic [PADDR_W-3:0] REG_HDR_OFFSET = '0;

endpackage : cowsb_pkg

`default_nettype wire

// File: sv/cowsb_ram.sv
// ----------------------------------------------------------------------------
// cowsb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cowsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : cowsb_ram

`default_nettype wire

// File: sv/cow_sector_bitmap_engine_top.sv
// ----------------------------------------------------------------------------
// cow_sector_bitmap_engine_top
// Copy-on-write dirty-sector bitmap: read lookup, write marking, word preload.
// ----------------------------------------------------------------------------
// Steps: read/write S_RD0, S_RD1, S_CALC, S_WR1, S_OUT; load S_LDW, S_OUT;
//   read/write error or unused operation S_OUT. Next request accepted the
//   cycle after the result is registered: one request at a time, set by the
//   two-word read-modify-write through the single read and single write port.
// Reset: a clearing pass zeroes all 2048 bitmap words, one per cycle;
//   req_ready stays low until the pass ends. APB writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module cow_sector_bitmap_engine_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cowsb_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // request
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic [1:0]                      operation,
  input  wire logic [cowsb_pkg::SECTOR_W-1:0]  start_sector,
  input  wire logic [cowsb_pkg::COUNT_W-1:0]   sector_count,
  input  wire logic [cowsb_pkg::WORD_IDX_W-1:0] word_index,
  input  wire logic [cowsb_pkg::WORD_BITS-1:0] word_value,
  // response
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic      [cowsb_pkg::MASK_BITS-1:0] overlay_mask,
  output logic                                 bitmap_changed,
  output logic      [cowsb_pkg::WORD_IDX_W-1:0] first_word,
  output logic      [cowsb_pkg::END_W-1:0]     end_word,
  output logic      [1:0]                      status
);

  import cowsb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_CALC, S_WR1, S_LDW, S_OUT
  } state_t;

  localparam int SUM_W = SECTOR_W + 1;

  state_t                  state;
  logic [WORD_IDX_W-1:0]   clr_addr;
  logic [31:0]             hdr_offset;

  op_t                     op_q;
  logic [SECTOR_W-1:0]     start_q;
  logic [COUNT_W-1:0]      count_q;
  logic [WORD_IDX_W-1:0]   widx_q;
  logic [WORD_BITS-1:0]    wval_q;
  status_t                 stat_q;
  logic [WORD_BITS-1:0]    word0;
  logic [WORD_BITS-1:0]    word1;
  logic [MASK_BITS-1:0]    cmask;
  logic [2*WORD_BITS-1:0]  m64;

  logic [MASK_BITS-1:0]    res_mask;
  logic                    res_changed;
  logic [WORD_IDX_W-1:0]   res_first;
  logic [END_W-1:0]        res_end;

  logic                    ram_we;
  logic [WORD_IDX_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0]    ram_wdata;
  logic [WORD_IDX_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0]    ram_rdata;

  logic [WORD_IDX_W-1:0]   w0;
  logic [WORD_IDX_W-1:0]   w1;
  logic                    wr_ok;
  logic [SUM_W-1:0]        req_sum;
  logic [SUM_W-1:0]        q_sum;
  status_t                 req_status;
  logic [2*WORD_BITS-1:0]  window;
  logic [2*WORD_BITS-1:0]  window_sh;
  logic                    new_bits;
  logic                    cfg_wr;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[PADDR_W-1:2] == REG_HDR_OFFSET) ? hdr_offset : 32'd0;

  assign req_ready = (state == S_IDLE);

  assign w0     = start_q[SECTOR_W-1:BIT_OFF_W];
  assign w1     = w0 + WORD_IDX_W'(1);
  assign wr_ok  = (op_q == OP_WRITE) && (stat_q == ST_OK);
  assign q_sum  = {1'b0, start_q} + SUM_W'(count_q);
  assign window    = {ram_rdata, word0};
  assign window_sh = window >> start_q[BIT_OFF_W-1:0];
  assign new_bits  = |(m64 & ~window);

  assign req_sum = {1'b0, start_sector} + SUM_W'(sector_count);

  always_comb begin
    priority if (operation == OP_LOAD) begin
      req_status = ({1'b0, word_index} < (WORD_IDX_W+1)'(BITMAP_WORDS)) ? ST_OK : ST_BEYOND;
    end else if (operation == OP_NONE) begin
      req_status = ST_OK;
    end else if (32'(sector_count) > 32'(MASK_BITS)) begin
      req_status = ST_TOO_LONG;
    end else if (32'(req_sum) > 32'(DISK_SECTORS)) begin
      req_status = ST_BEYOND;
    end else begin
      req_status = ST_OK;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w0;
    ram_wdata = '0;
    ram_raddr = w0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_RD1: begin
        ram_raddr = w1;
      end
      S_CALC: begin
        ram_we    = wr_ok;
        ram_wdata = word0 | m64[WORD_BITS-1:0];
      end
      S_WR1: begin
        ram_we    = wr_ok && (|m64[2*WORD_BITS-1:WORD_BITS]);
        ram_waddr = w1;
        ram_wdata = word1 | m64[2*WORD_BITS-1:WORD_BITS];
      end
      S_LDW: begin
        ram_we    = (stat_q == ST_OK);
        ram_waddr = widx_q;
        ram_wdata = wval_q;
      end
      S_IDLE, S_RD0, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  cowsb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      hdr_offset <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[PADDR_W-1:2] == REG_HDR_OFFSET)) begin
        hdr_offset <= pwdata;
      end
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WORD_IDX_W'(1);
          if (clr_addr == WORD_IDX_W'(BITMAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_q        <= op_t'(operation);
            start_q     <= start_sector;
            count_q     <= sector_count;
            widx_q      <= word_index;
            wval_q      <= word_value;
            stat_q      <= req_status;
            res_mask    <= '0;
            res_changed <= 1'b0;
            res_first   <= '0;
            res_end     <= '0;
            priority if (operation == OP_LOAD) begin
              state <= S_LDW;
            end else if ((operation != OP_NONE) && (req_status == ST_OK)) begin
              state <= S_RD0;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD0: begin
          cmask <= MASK_BITS'(((MASK_BITS+1)'(1) << count_q[$clog2(MASK_BITS+1)-1:0])
                              - (MASK_BITS+1)'(1));
          state <= S_RD1;
        end
        S_RD1: begin
          word0 <= ram_rdata;
          m64   <= (2*WORD_BITS)'(cmask) << start_q[BIT_OFF_W-1:0];
          state <= S_CALC;
        end
        S_CALC: begin
          word1 <= ram_rdata;
          if (op_q == OP_WRITE) begin
            res_mask    <= cmask;
            res_changed <= new_bits;
            if (new_bits) begin
              res_first <= w0;
              res_end   <= END_W'(q_sum >> BIT_OFF_W) + END_W'(1);
            end
          end else begin
            res_mask <= window_sh[MASK_BITS-1:0] & cmask;
          end
          state <= S_WR1;
        end
        S_WR1: begin
          state <= S_OUT;
        end
        S_LDW: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            overlay_mask   <= res_mask;
            bitmap_changed <= res_changed;
            first_word     <= res_first;
            end_word       <= res_end;
            status         <= stat_q;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : cow_sector_bitmap_engine_top

`default_nettype wire
